FILE: rtl/cvc_pkg.sv
// cvc_pkg: shared types, register indexes and helpers for the character cipher
// no dependencies; imported by cvc_keystream, cvc_rotate and the top level
`default_nettype none

package cvc_pkg;

   // keyword table size and field widths
   localparam int MAX_KEY_LETTERS = 12;
   localparam int ENTRY_W         = 5;
   localparam int POS_W           = 4;
   localparam int KEYS_W          = MAX_KEY_LETTERS * ENTRY_W;
   localparam int CSR_IDX_W       = 3;

   // alphabet constants
   localparam logic [7:0] UPPER_A  = 8'd65;
   localparam logic [7:0] UPPER_Z  = 8'd90;
   localparam logic [7:0] LOWER_A  = 8'd97;
   localparam logic [7:0] LOWER_Z  = 8'd122;
   localparam logic [5:0] ALPHA_N  = 6'd26;
   localparam logic [4:0] ROT_HALF = 5'd13;

   // cipher modes
   localparam logic [1:0] MODE_SHIFT = 2'd0;
   localparam logic [1:0] MODE_WORD  = 2'd1;
   localparam logic [1:0] MODE_CHAIN = 2'd2;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CIPHER_MODE  = 3'd0,
      CSR_DECRYPT      = 3'd1,
      CSR_SHIFT_METHOD = 3'd2,
      CSR_KEY_SHIFT    = 3'd3,
      CSR_KEY_LETTERS  = 3'd4,
      CSR_KEY_COUNT    = 3'd5
   } csr_index_type;

   // configuration held by the top level
   typedef struct packed {
      logic [1:0]        cipher_mode;
      logic              decrypt;
      logic              shift_method;
      logic [4:0]        key_shift;
      logic [KEYS_W-1:0] key_letters;
      logic [POS_W-1:0]  key_count;
   } cfg_type;

   // reduce a value below 52 modulo 26
   function automatic logic [4:0] mod26(input logic [5:0] v);
      logic [5:0] r;
      r = (v >= ALPHA_N) ? (v - ALPHA_N) : v;
      return r[4:0];
   endfunction

   // letter detection
   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= UPPER_A) && (c <= UPPER_Z)) || ((c >= LOWER_A) && (c <= LOWER_Z));
   endfunction

endpackage

`default_nettype wire

FILE: rtl/cvc_keystream.sv
// cvc_keystream: keyword position register and per-character shift amount
// depends on cvc_pkg
`default_nettype none

module cvc_keystream import cvc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic [7:0] in_byte,
   input  wire logic       msg_start,
   input  wire logic       step,
   output logic      [4:0] shift_amt
);

   logic [POS_W-1:0]   key_position_ff;
   logic [POS_W-1:0]   key_position_in;
   logic [POS_W-1:0]   count;
   logic [POS_W-1:0]   pos_start;
   logic [POS_W-1:0]   sel;
   logic [POS_W-1:0]   pos_inc;
   logic [ENTRY_W-1:0] entries [MAX_KEY_LETTERS];
   logic [4:0]         l1_shift;
   logic [4:0]         l2_shift;
   logic [4:0]         sum_mod;
   logic               use_l1;
   logic               use_l2;
   logic               letter;

   // unpack keyword table
   for (genvar k = 0; k < MAX_KEY_LETTERS; k++) begin : g_entry
      assign entries[k] = cfg.key_letters[k*ENTRY_W +: ENTRY_W];
   end

   // layer selection
   always_comb begin
      count = (cfg.key_count > POS_W'(MAX_KEY_LETTERS)) ? POS_W'(MAX_KEY_LETTERS)
                                                        : cfg.key_count;
      use_l1 = 1'b0;
      use_l2 = 1'b0;
      unique case (cfg.cipher_mode)
         MODE_SHIFT: begin
            use_l1 = 1'b1;
         end
         MODE_WORD: begin
            use_l2 = (count != '0);
         end
         MODE_CHAIN: begin
            use_l2 = (count != '0);
            use_l1 = (count != '0);
         end
         default: begin
            use_l1 = 1'b0;
            use_l2 = 1'b0;
         end
      endcase
   end

   // shift amounts of both layers
   always_comb begin
      letter    = is_letter(in_byte);
      pos_start = msg_start ? '0 : key_position_ff;
      sel       = (pos_start < count) ? pos_start : '0;
      l1_shift  = '0;
      if (use_l1) begin
         l1_shift = cfg.shift_method ? mod26({1'b0, cfg.key_shift}) : ROT_HALF;
      end
      l2_shift = '0;
      if (use_l2 && letter) begin
         l2_shift = mod26({1'b0, entries[sel]});
      end
      sum_mod   = mod26({1'b0, l1_shift} + {1'b0, l2_shift});
      shift_amt = (cfg.decrypt && (sum_mod != '0)) ? 5'(ALPHA_N - {1'b0, sum_mod})
                                                   : sum_mod;
   end

   // next keyword position
   always_comb begin
      pos_inc         = sel + POS_W'(1);
      key_position_in = pos_start;
      if (use_l2 && letter) begin
         key_position_in = (pos_inc >= count) ? '0 : pos_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_position_ff <= '0;
      end else if (step) begin
         key_position_ff <= key_position_in;
      end
   end

   // position stays inside the keyword table
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      key_position_ff < POS_W'(MAX_KEY_LETTERS))
      else $error("keyword position out of range");

   // shift is always a valid alphabet offset
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      shift_amt < 5'(ALPHA_N))
      else $error("shift amount out of range");

   // position only moves on a step
   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(key_position_ff))
      else $error("keyword position changed without a step");

endmodule

`default_nettype wire

FILE: rtl/cvc_rotate.sv
// cvc_rotate: rotates a letter within its own alphabet, other bytes pass
// depends on cvc_pkg
`default_nettype none

module cvc_rotate import cvc_pkg::*; (
   input  wire logic [7:0] in_byte,
   input  wire logic [4:0] shift_amt,
   output logic      [7:0] out_byte
);

   logic [7:0] base;
   logic [7:0] offset;
   logic [4:0] rotated;
   logic       upper;
   logic       lower;

   // pick the alphabet and wrap the offset
   always_comb begin
      upper    = (in_byte >= UPPER_A) && (in_byte <= UPPER_Z);
      lower    = (in_byte >= LOWER_A) && (in_byte <= LOWER_Z);
      base     = upper ? UPPER_A : LOWER_A;
      offset   = in_byte - base;
      rotated  = mod26({1'b0, offset[4:0]} + {1'b0, shift_amt});
      out_byte = (upper || lower) ? (base + {3'b000, rotated}) : in_byte;
   end

endmodule

`default_nettype wire

FILE: rtl/caesar_vigenere_char_cipher.sv
// caesar_vigenere_char_cipher: a req transfer loads the input register, which in turn
// loads the result register that drives rsp valid; throughput one character per cycle
// while rsp is not stalled; the keyword position register is the only state carried
// between characters; synchronous active-high reset clears the configuration, the
// keyword position and both pipeline valids
// depends on cvc_pkg, cvc_keystream, cvc_rotate
`default_nettype none

module caesar_vigenere_char_cipher import cvc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_in_byte,
   input  wire logic                 req_msg_start,
   // response channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [7:0]           rsp_out_byte,
   // configuration channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [KEYS_W-1:0]    csr_wdata
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic [7:0] out_byte_in;
   logic [4:0] shift_amt;
   logic       advance;
   logic       step;

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CIPHER_MODE:  cfg_ff.cipher_mode  <= csr_wdata[1:0];
            CSR_DECRYPT:      cfg_ff.decrypt      <= csr_wdata[0];
            CSR_SHIFT_METHOD: cfg_ff.shift_method <= csr_wdata[0];
            CSR_KEY_SHIFT:    cfg_ff.key_shift    <= csr_wdata[4:0];
            CSR_KEY_LETTERS:  cfg_ff.key_letters  <= csr_wdata;
            CSR_KEY_COUNT:    cfg_ff.key_count    <= csr_wdata[POS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // pipeline flow control
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff  <= req_in_byte;
         in_start_ff <= req_msg_start;
      end
   end

   // shift amount and keyword position
   cvc_keystream u_keystream (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_byte   (in_byte_ff),
      .msg_start (in_start_ff),
      .step      (step),
      .shift_amt (shift_amt)
   );

   // letter rotation
   cvc_rotate u_rotate (
      .in_byte   (in_byte_ff),
      .shift_amt (shift_amt),
      .out_byte  (out_byte_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_byte_ff <= out_byte_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;

   // request side only stalls behind a full, stalled result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && rsp_stall && in_valid_ff))
      else $error("request stalled without a blocked result");

   // a stalled result keeps its byte
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_byte_ff)))
      else $error("stalled result changed");

   // an accepted character reaches the result register next cycle when not blocked
   a_flow: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("character lost between stages");

endmodule

`default_nettype wire
